### hw/rtl/lacq_pkg.sv
// Shared types, constants and a helper for the line assembler command queue.
package lacq_pkg;

  localparam int LINE_BYTES  = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam int LEN_W    = $clog2(LINE_BYTES);
  localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int CS_DEPTH = QUEUE_DEPTH << LEN_W;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
    logic [7:0] out_limit;
  } req_t;

  typedef struct packed {
    logic       found;
    logic       char_valid;
    logic [7:0] char_byte;
    logic       last;
  } rsp_t;

  // Advance a queue slot index with wrap.
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

### hw/rtl/lacq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lacq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/line_assembler_command_queue.sv
// Top level: assembles received bytes into lines and queues them as commands.
//
// In a push (mode 0), a CR or LF that ends a non-empty line starts a copy of
// the line buffer into the command slot at the queue tail, one byte per cycle
// through the line buffer read port, with the input stalled. A read (mode 1)
// on an empty queue or with a limit of zero or one gives one result at once;
// otherwise each streamed byte is addressed, then checked in the registered
// command store read data. The input is stalled while a copy or a read is in
// progress and while a result waits in the output register and cannot leave
// in the same cycle.
module line_assembler_command_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lacq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lacq_pkg::rsp_t rsp
);
  import lacq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COPY  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;

  logic [2:0]        state;
  logic [LEN_W-1:0]  plen;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [CNT_W-1:0]  count;
  logic [LEN_W-1:0]  lens [QUEUE_DEPTH];
  logic [SLOT_W-1:0] slot;
  logic [LEN_W-1:0]  idx;
  logic [LEN_W-1:0]  cp_len;
  logic [LEN_W-1:0]  cp_widx;
  logic              cp_pend;
  logic [LEN_W-1:0]  mlen;
  logic [7:0]        pend;
  logic              have_pend;

  logic              acc;
  logic              out_free;
  logic              is_term;
  logic              q_empty_rd;
  logic [7:0]        lim_m1;
  logic [LEN_W-1:0]  head_len;
  logic [LEN_W-1:0]  m_calc;
  logic              last_idx;
  logic              cp_issue;
  logic              emit;
  rsp_t              emit_data;

  logic              pl_we;
  logic              pl_re;
  logic [7:0]        pl_rdata;
  logic              cs_we;
  logic              cs_re;
  logic [7:0]        cs_rdata;

  // Handshake and decode
  assign out_free   = !rsp_valid || !rsp_stall;
  assign req_stall  = (state != S_IDLE) || !out_free;
  assign acc        = req_valid && !req_stall;
  assign is_term    = (req.rx_byte == CHAR_CR) || (req.rx_byte == CHAR_LF);
  assign q_empty_rd = (req.out_limit == 8'd0) || (count == '0);
  assign lim_m1     = req.out_limit - 8'd1;
  assign head_len   = lens[head];
  assign m_calc     = ({{(8 - LEN_W){1'b0}}, head_len} < lim_m1) ? head_len
                                                                : lim_m1[LEN_W-1:0];
  assign last_idx   = ({1'b0, idx} + 1'b1) == {1'b0, mlen};
  assign cp_issue   = (state == S_COPY) && (idx != cp_len);

  // Memory port controls
  assign pl_we = acc && (req.mode == MODE_PUSH) && !is_term
                 && (plen < LEN_W'(LINE_BYTES - 1));
  assign pl_re = cp_issue;
  assign cs_we = (state == S_COPY) && cp_pend;
  assign cs_re = (state == S_FETCH);

  lacq_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (plen),
    .wdata (req.rx_byte),
    .re    (pl_re),
    .raddr (idx),
    .rdata (pl_rdata)
  );

  lacq_ram #(
    .WIDTH (8),
    .DEPTH (CS_DEPTH)
  ) u_cmd_ram (
    .clk   (clk),
    .we    (cs_we),
    .waddr ({slot, cp_widx}),
    .wdata (pl_rdata),
    .re    (cs_re),
    .raddr ({slot, idx}),
    .rdata (cs_rdata)
  );

  // Pick the result to load into the output register
  always_comb begin
    emit      = 1'b0;
    emit_data = '{found: 1'b0, char_valid: 1'b0, char_byte: 8'd0, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (acc && (req.mode == MODE_READ)) begin
          if (q_empty_rd) begin
            emit = 1'b1;
          end else if (m_calc == '0) begin
            emit            = 1'b1;
            emit_data.found = 1'b1;
          end
        end
      end
      S_LOOK: begin
        if (out_free) begin
          if (cs_rdata == 8'd0) begin
            emit            = 1'b1;
            emit_data.found = 1'b1;
            if (have_pend) begin
              emit_data.char_valid = 1'b1;
              emit_data.char_byte  = pend;
            end
          end else if (have_pend) begin
            emit      = 1'b1;
            emit_data = '{found: 1'b1, char_valid: 1'b1, char_byte: pend, last: 1'b0};
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = '{found: 1'b1, char_valid: 1'b1, char_byte: pend, last: 1'b1};
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Output register: load on a new result, drop after a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= emit_data;
    end
  end

  // Slot length table, written when a line is queued
  always_ff @(posedge clk) begin
    if (acc && (req.mode == MODE_PUSH) && is_term && (plen != '0)) begin
      lens[tail] <= plen;
    end
  end

  // Sequencer: line assembly, line copy and command streaming
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      plen      <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      cp_pend   <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (req.mode == MODE_PUSH) begin
              if (is_term) begin
                if (plen != '0) begin
                  // Queue the line, dropping the oldest command when full
                  tail <= slot_inc(tail);
                  if (count == CNT_W'(QUEUE_DEPTH)) begin
                    head <= slot_inc(head);
                  end else begin
                    count <= count + 1'b1;
                  end
                  slot    <= tail;
                  cp_len  <= plen;
                  idx     <= '0;
                  cp_pend <= 1'b0;
                  state   <= S_COPY;
                end
                plen <= '0;
              end else if (plen < LEN_W'(LINE_BYTES - 1)) begin
                plen <= plen + 1'b1;
              end else begin
                // Overflow: drop the byte and the whole line
                plen <= '0;
              end
            end else if (!q_empty_rd) begin
              // Dequeue the oldest command and start streaming it
              head      <= slot_inc(head);
              count     <= count - 1'b1;
              slot      <= head;
              mlen      <= m_calc;
              idx       <= '0;
              have_pend <= 1'b0;
              if (m_calc != '0) begin
                state <= S_FETCH;
              end
            end
          end
        end
        S_COPY: begin
          // Read one byte per cycle, write it in the next cycle
          if (cp_issue) begin
            idx <= idx + 1'b1;
          end
          cp_pend <= cp_issue;
          cp_widx <= idx;
          if (!cp_issue && !cp_pend) begin
            state <= S_IDLE;
          end
        end
        S_FETCH: begin
          state <= S_LOOK;
        end
        S_LOOK: begin
          if (out_free) begin
            if (cs_rdata == 8'd0) begin
              state <= S_IDLE;
            end else begin
              pend      <= cs_rdata;
              have_pend <= 1'b1;
              if (last_idx) begin
                state <= S_TAIL;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_FETCH;
              end
            end
          end
        end
        S_TAIL: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### bench/lacq_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the command queue read results.
package lacq_scoreboard_pkg;
  import lacq_pkg::*;

  class command_scoreboard;
    logic [7:0]        line_buf [LINE_BYTES];
    logic [LEN_W-1:0]  line_len;
    logic [7:0]        slot_bytes [QUEUE_DEPTH][LINE_BYTES];
    logic [LEN_W-1:0]  slot_len [QUEUE_DEPTH];
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
    logic [CNT_W-1:0]  count;
    rsp_t              awaited [$];
    int                fails;

    function new();
      line_len = '0;
      head     = '0;
      tail     = '0;
      count    = '0;
      fails    = 0;
    endfunction

    // Copy the finished line into the tail slot, evicting the oldest when full.
    function void queue_line();
      if (count == CNT_W'(QUEUE_DEPTH)) begin
        head  = SLOT_W'((int'(head) + 1) % QUEUE_DEPTH);
        count = count - 1'b1;
      end
      for (int i = 0; i < int'(line_len); i++) begin
        slot_bytes[tail][i] = line_buf[i];
      end
      slot_len[tail] = line_len;
      tail  = SLOT_W'((int'(tail) + 1) % QUEUE_DEPTH);
      count = count + 1'b1;
    endfunction

    // Append a byte, end the line on CR/LF, or drop the line on overflow.
    function void push_rx_byte(logic [7:0] b);
      if (b == CHAR_CR || b == CHAR_LF) begin
        if (line_len != '0) begin
          queue_line();
        end
        line_len = '0;
      end else if (int'(line_len) < LINE_BYTES - 1) begin
        line_buf[line_len] = b;
        line_len = line_len + 1'b1;
      end else begin
        line_len = '0;
      end
    endfunction

    // Dequeue the oldest command and queue the characters it streams.
    function void dequeue_command(logic [7:0] limit);
      rsp_t              r;
      int                n;
      int                len;
      logic [SLOT_W-1:0] slot;
      r = '0;
      if (limit == 8'd0 || count == '0) begin
        r.last = 1'b1;
        awaited.push_back(r);
        return;
      end
      slot = head;
      len  = int'(slot_len[slot]);
      n    = 0;
      while (n < len && slot_bytes[slot][n] != 8'h00) n++;
      if (n >= int'(limit)) n = int'(limit) - 1;
      head  = SLOT_W'((int'(slot) + 1) % QUEUE_DEPTH);
      count = count - 1'b1;
      r.found = 1'b1;
      if (n == 0) begin
        r.last = 1'b1;
        awaited.push_back(r);
        return;
      end
      for (int i = 0; i < n; i++) begin
        r.char_valid = 1'b1;
        r.char_byte  = slot_bytes[slot][i];
        r.last       = (i == n - 1);
        awaited.push_back(r);
      end
    endfunction

    // Advance the model on an accepted input transfer.
    function void note_request(req_t item);
      if (item.mode == MODE_PUSH) begin
        push_rx_byte(item.rx_byte);
      end else begin
        dequeue_command(item.out_limit);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (want_v !== got_v) begin
        $error("%s: expected %0h, got %0h", name, want_v, got_v);
        fails++;
      end
    endfunction

    // Match an output transfer against the oldest awaited character.
    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: found=%0b char_valid=%0b char_byte=%0h last=%0b",
               got.found, got.char_valid, got.char_byte, got.last);
        fails++;
        return;
      end
      want = awaited.pop_front();
      compare_field("found", 8'(want.found), 8'(got.found));
      compare_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
      compare_field("char_byte", want.char_byte, got.char_byte);
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

endpackage

### bench/testbench.sv
// Top-level bench: drives bytes and reads into the command queue and checks results.
module testbench;
  import lacq_pkg::*;
  import lacq_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TARGET_ITEMS = 350;
  localparam int QUIET_ITEMS  = 300;
  localparam int DRAIN_CYCLES = 200;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  command_scoreboard sb = new();

  bit idle_on = 1'b1;
  bit calm    = 1'b0;
  int items_sent  = 0;
  int stall_left  = 0;
  int cycle_count = 0;

  line_assembler_command_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  // Abort on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stall the result side in short random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_response(rsp);
    end
  end

  // Present one input and hold it until the transfer happens.
  task automatic send_item(input req_t item);
    int gap;
    if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(item);
    items_sent++;
  endtask

  task automatic send_push(input logic [7:0] b);
    req_t item;
    item.mode      = MODE_PUSH;
    item.rx_byte   = b;
    item.out_limit = 8'($urandom);
    send_item(item);
  endtask

  task automatic send_read(input logic [7:0] limit);
    req_t item;
    item.mode      = MODE_READ;
    item.rx_byte   = 8'($urandom);
    item.out_limit = limit;
    send_item(item);
  endtask

  // Pick a line byte: never a terminator, sometimes zero.
  function automatic logic [7:0] line_char();
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) return 8'h00;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  function automatic logic [7:0] read_limit();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      3:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(2, 20));
    endcase
  endfunction

  task automatic send_line(input int len);
    for (int i = 0; i < len; i++) send_push(line_char());
  endtask

  task automatic send_terminator();
    send_push($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
  endtask

  initial begin
    int lines;
    int reads;
    int len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Read from the empty queue, then an empty line.
    send_read(8'd5);
    send_push(CHAR_LF);
    // Five commands into four slots: the first is evicted.
    send_push(8'hFF);
    send_push(8'h01);
    send_push(CHAR_CR);
    send_push(8'h00);
    send_push(8'h42);
    send_push(CHAR_LF);
    send_push(8'h43);
    send_push(8'h00);
    send_push(8'h45);
    send_push(CHAR_CR);
    send_push(8'h46);
    send_push(CHAR_CR);
    send_push(8'h47);
    send_push(CHAR_LF);
    // Zero limit leaves the queue alone; then leading zero, inner zero,
    // limit of one, a limit of two on a one-byte command, and empty again.
    send_read(8'd0);
    send_read(8'd255);
    send_read(8'd255);
    send_read(8'd1);
    send_read(8'd2);
    send_read(8'd255);

    // Longest line, then an overflowed line followed by a short one.
    send_line(LINE_BYTES - 1);
    send_terminator();
    send_read(8'd255);
    send_line(LINE_BYTES - 1);
    send_push(line_char());
    send_line(2);
    send_terminator();
    send_read(8'd255);

    // Mostly well-formed lines and reads, with some loose bytes and reads.
    while (items_sent < TARGET_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      if (items_sent > QUIET_ITEMS) idle_on = 1'b0;
      if ($urandom_range(0, 9) < 2) begin
        if ($urandom_range(0, 1)) begin
          send_push(8'($urandom_range(0, 255)));
        end else begin
          send_read(read_limit());
        end
      end else begin
        lines = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
        for (int i = 0; i < lines; i++) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
          send_line(len);
          send_terminator();
        end
        reads = $urandom_range(0, lines + 1);
        for (int i = 0; i < reads; i++) send_read(read_limit());
      end
    end
    req_valid <= 1'b0;
    calm    = 1'b0;
    idle_on = 1'b0;

    // Drain results, then allow a trailing copy or stray result to show.
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
